FILE: hw/rtl/gradient_edge_threshold_macros.svh
// Assertion macros used by the edge threshold RTL.
`ifndef GRADIENT_EDGE_THRESHOLD_MACROS_SVH
`define GRADIENT_EDGE_THRESHOLD_MACROS_SVH
`ifndef SYNTH
`define GEDT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gradient_edge_threshold: same-cycle check failed");
`define GEDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gradient_edge_threshold: next-cycle check failed");
`else
`define GEDT_ASSERT_NOW(lbl, ante, cons)
`define GEDT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/gedt_pkg.sv
// Constants, types and helpers of the gradient edge threshold block.
`default_nettype none
package gedt_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W = $clog2(MAX_WIDTH);

    localparam int PIX_W = 8;
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 16;
    localparam int THR_W = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [IMG_W_W-1:0] RESET_WIDTH = 11'd256;
    localparam logic [IMG_H_W-1:0] RESET_HEIGHT = 16'd256;
    localparam logic [THR_W-1:0] RESET_THRESHOLD = 17'd900;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD_SQ = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic x_ge1;
        logic x_ge2;
        logic y_ge1;
        logic y_ge2;
        logic row_end;
        logic last_row;
    } t_pos;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] u,
                                                  input logic [PIX_W-1:0] v);
        return (u >= v) ? (u - v) : (v - u);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gradient_edge_threshold.sv
// Streaming central-difference gradient edge marker with line stores.
`default_nettype none
`include "gradient_edge_threshold_macros.svh"
// The block takes one grey pixel per transaction in raster order and returns edge marks
// one row and one pixel behind the input. Once a row lies above it, a pixel past the first
// column causes one result and a row end one more; on the last row each of these positions
// adds one more result, so an item causes zero to four results. The single result register
// hands them out one per cycle while the output is ready, and then pixels with at most one
// result each are taken every cycle. A stage register in front of the result register takes
// one more pixel while a result waits. The two line stores need no clearing pass; entries
// read before being written only feed results the position flags drop. Configuration writes
// take effect once registered; the user makes them between frames, unenforced by the block.
module gradient_edge_threshold (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,   // [7:0] pixel_value
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [7:0]                              m_axis_tdata,   // [0] is_edge, rest zero
    output logic                                    m_axis_tlast,   // last_of_run
    output logic [0:0]                              m_axis_tuser,   // [0] end_of_frame
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [gedt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gedt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = gedt_pkg::ADDR_W;
    localparam int PW = gedt_pkg::PIX_W;

    logic [gedt_pkg::IMG_W_W-1:0] r_image_width;
    logic [gedt_pkg::IMG_H_W-1:0] r_image_height;
    logic [gedt_pkg::THR_W-1:0]   r_threshold_sq;

    logic [AW-1:0]                w_last;
    logic [gedt_pkg::IMG_H_W-1:0] h_last;
    logic [AW-1:0]                x_c;
    logic [gedt_pkg::IMG_H_W-1:0] y_c;
    gedt_pkg::t_pos               pos;

    logic [AW-1:0]                r_col;
    logic [gedt_pkg::IMG_H_W-1:0] r_row;
    logic [AW-1:0]                n_col;
    logic [gedt_pkg::IMG_H_W-1:0] n_row;

    logic [PW-1:0] r_above_mem [gedt_pkg::MAX_WIDTH];
    logic [PW-1:0] r_two_mem [gedt_pkg::MAX_WIDTH];
    logic [PW-1:0] r_a;
    logic [PW-1:0] r_b;
    logic          r_byp;
    logic [PW-1:0] r_byp_data;
    logic          r_wr2_pend;
    logic [AW-1:0] r_wr2_addr;

    logic           r_s1_valid;
    logic [PW-1:0]  r_s1_pix;
    gedt_pkg::t_pos r_s1_pos;

    logic [PW-1:0] r_above_hist0;
    logic [PW-1:0] r_above_hist1;
    logic [PW-1:0] r_left0;
    logic [PW-1:0] r_left1;
    logic [PW-1:0] r_top_prev;

    logic [3:0] r_run_mask;
    logic [3:0] r_run_edge;
    logic       r_run_eof;

    logic          accept;
    logic          run_valid;
    logic          run_last;
    logic          run_take;
    logic          run_free;
    logic          s1_adv;
    logic [3:0]    run_sel;
    logic [PW-1:0] b_eff;
    logic [PW-1:0] d1x;
    logic [PW-1:0] d1y;
    logic [PW-1:0] d2x;
    logic [PW-1:0] d3y;
    logic [15:0]   sq1x;
    logic [15:0]   sq1y;
    logic [15:0]   sq2x;
    logic [15:0]   sq3y;
    logic [gedt_pkg::THR_W-1:0] sum1;
    logic [3:0]    s1_mask;
    logic [3:0]    s1_edge;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= gedt_pkg::RESET_WIDTH;
            r_image_height <= gedt_pkg::RESET_HEIGHT;
            r_threshold_sq <= gedt_pkg::RESET_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (gedt_pkg::t_cfg_idx'(i_cfg_index))
                gedt_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[gedt_pkg::IMG_W_W-1:0];
                end
                gedt_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[gedt_pkg::IMG_H_W-1:0];
                end
                gedt_pkg::CFG_THRESHOLD_SQ: begin
                    r_threshold_sq <= i_cfg_data[gedt_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Frame geometry and position of the incoming pixel.
    always_comb begin
        if (r_image_width == '0) begin
            w_last = '0;
        end else if (32'(r_image_width) > 32'(gedt_pkg::MAX_WIDTH)) begin
            w_last = AW'(gedt_pkg::MAX_WIDTH - 1);
        end else begin
            w_last = AW'(32'(r_image_width) - 32'd1);
        end
        h_last = (r_image_height == '0) ? '0 : r_image_height - 16'd1;
        x_c = (r_col > w_last) ? w_last : r_col;
        y_c = (r_row > h_last) ? h_last : r_row;
        pos.x_ge1    = (x_c != '0);
        pos.x_ge2    = (x_c > AW'(1));
        pos.y_ge1    = (y_c != '0);
        pos.y_ge2    = (y_c > 16'd1);
        pos.row_end  = (x_c == w_last);
        pos.last_row = (y_c == h_last);
        if (pos.row_end) begin
            n_col = '0;
            n_row = pos.last_row ? '0 : y_c + 16'd1;
        end else begin
            n_col = x_c + AW'(1);
            n_row = y_c;
        end
    end

    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores: the row above is rewritten as it is read, the row two above in the cycle after.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= r_above_mem[x_c];
            r_above_mem[x_c] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b <= r_two_mem[x_c];
        end
        if (r_wr2_pend) begin
            r_two_mem[r_wr2_addr] <= r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr2_pend <= 1'b0;
        end else begin
            r_wr2_pend <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wr2_addr <= x_c;
            r_byp      <= r_wr2_pend && (r_wr2_addr == x_c);
            r_byp_data <= r_a;
            r_s1_pix   <= s_axis_tdata;
            r_s1_pos   <= pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    // Gradient and threshold for the results of the item in the stage register.
    always_comb begin
        b_eff = r_byp ? r_byp_data : r_b;
        d1x = r_s1_pos.x_ge2 ? gedt_pkg::abs_diff(r_a, r_above_hist1) : '0;
        d1y = r_s1_pos.y_ge2 ? gedt_pkg::abs_diff(r_top_prev, r_left0) : '0;
        d2x = r_s1_pos.x_ge2 ? gedt_pkg::abs_diff(r_s1_pix, r_left1) : '0;
        d3y = r_s1_pos.y_ge2 ? gedt_pkg::abs_diff(b_eff, r_s1_pix) : '0;
        sq1x = {8'd0, d1x} * {8'd0, d1x};
        sq1y = {8'd0, d1y} * {8'd0, d1y};
        sq2x = {8'd0, d2x} * {8'd0, d2x};
        sq3y = {8'd0, d3y} * {8'd0, d3y};
        sum1 = {1'b0, sq1x} + {1'b0, sq1y};
        s1_edge = {1'b0,
                   ({1'b0, sq3y} > r_threshold_sq),
                   ({1'b0, sq2x} > r_threshold_sq),
                   (sum1 > r_threshold_sq)};
        s1_mask = {r_s1_pos.row_end && r_s1_pos.last_row,
                   r_s1_pos.row_end && r_s1_pos.y_ge1,
                   r_s1_pos.x_ge1 && r_s1_pos.last_row,
                   r_s1_pos.x_ge1 && r_s1_pos.y_ge1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above_hist0 <= '0;
            r_above_hist1 <= '0;
            r_left0       <= '0;
            r_left1       <= '0;
            r_top_prev    <= '0;
        end else if (s1_adv) begin
            r_above_hist1 <= r_above_hist0;
            r_above_hist0 <= r_a;
            r_left1       <= r_left0;
            r_left0       <= r_s1_pix;
            r_top_prev    <= b_eff;
        end
    end

    // Result register: hands out the results of one item in order, one per transaction.
    assign run_valid = |r_run_mask;
    assign run_sel   = r_run_mask & (~r_run_mask + 4'd1);
    assign run_last  = ((r_run_mask & (r_run_mask - 4'd1)) == 4'd0);
    assign run_take  = run_valid && m_axis_tready;
    assign run_free  = !run_valid || (run_take && run_last);
    assign s1_adv    = r_s1_valid && run_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mask <= '0;
        end else if (s1_adv) begin
            r_run_mask <= s1_mask;
        end else if (run_take) begin
            r_run_mask <= r_run_mask & (r_run_mask - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_run_edge <= s1_edge;
            r_run_eof  <= r_s1_pos.row_end && r_s1_pos.last_row;
        end
    end

    assign m_axis_tvalid = run_valid;
    assign m_axis_tdata  = {7'd0, |(r_run_edge & run_sel)};
    assign m_axis_tlast  = run_last;
    assign m_axis_tuser  = r_run_eof && run_last;

    `GEDT_ASSERT_NEXT(a_stage_fill, accept, r_s1_valid)
    `GEDT_ASSERT_NOW(a_wr2_in_stage, r_wr2_pend, r_s1_valid)
    `GEDT_ASSERT_NOW(a_bypass_width_one, r_s1_valid && r_byp, w_last == '0)
    `GEDT_ASSERT_NOW(a_eof_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    `GEDT_ASSERT_NEXT(a_row_wrap, accept && pos.row_end, r_col == '0)

endmodule
`default_nettype wire

FILE: verif/gradient_edge_threshold_tb.sv
// Self-checking testbench for the gradient edge threshold block.
`timescale 1ns / 1ps

class edge_mark_scoreboard;
    typedef struct {
        bit is_edge;
        bit last_of_run;
        bit end_of_frame;
    } t_mark;

    bit [gedt_pkg::IMG_W_W-1:0] width_reg;
    bit [gedt_pkg::IMG_H_W-1:0] height_reg;
    bit [gedt_pkg::THR_W-1:0]   thr_sq_reg;
    bit [7:0]    line_above[gedt_pkg::MAX_WIDTH];
    bit [7:0]    line_two_above[gedt_pkg::MAX_WIDTH];
    bit [7:0]    left_pix[2];
    bit [7:0]    above_recent[2];
    bit [7:0]    top_last;
    int unsigned col_cnt;
    int unsigned row_cnt;
    t_mark       marks_due[$];
    int unsigned mismatches;

    function new();
        width_reg = gedt_pkg::RESET_WIDTH;
        height_reg = gedt_pkg::RESET_HEIGHT;
        thr_sq_reg = gedt_pkg::RESET_THRESHOLD;
        col_cnt = 0;
        row_cnt = 0;
        mismatches = 0;
    endfunction

    function void write_reg(gedt_pkg::t_cfg_idx idx, bit [gedt_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            gedt_pkg::CFG_IMAGE_WIDTH: width_reg = value[gedt_pkg::IMG_W_W-1:0];
            gedt_pkg::CFG_IMAGE_HEIGHT: height_reg = value[gedt_pkg::IMG_H_W-1:0];
            gedt_pkg::CFG_THRESHOLD_SQ: thr_sq_reg = value[gedt_pkg::THR_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_width();
        int unsigned w = width_reg;
        if (w == 0) w = 1;
        if (w > gedt_pkg::MAX_WIDTH) w = gedt_pkg::MAX_WIDTH;
        return w;
    endfunction

    function int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function bit at_frame_start();
        return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int unsigned pending();
        return marks_due.size();
    endfunction

    function bit is_edge_at(int unsigned c, int unsigned r, int unsigned w, int unsigned h,
                            bit [7:0] p_left, bit [7:0] p_right,
                            bit [7:0] p_top, bit [7:0] p_bottom);
        int gx = 0;
        int gy = 0;
        if (c != 0 && c != w - 1) gx = int'(p_right) - int'(p_left);
        if (r != 0 && r != h - 1) gy = int'(p_top) - int'(p_bottom);
        return (gx * gx + gy * gy) > int'(thr_sq_reg);
    endfunction

    function void note_pixel(bit [7:0] p);
        int unsigned w = eff_width();
        int unsigned h = eff_height();
        int unsigned x = col_cnt;
        int unsigned y = row_cnt;
        bit [7:0] a;
        bit [7:0] b;
        bit row_end;
        bit last_row;
        bit edges[$];
        t_mark m;
        if (x > w - 1) x = w - 1;
        if (y > h - 1) y = h - 1;
        row_end = (x == w - 1);
        last_row = (y == h - 1);
        a = line_above[x];
        b = line_two_above[x];
        if (x >= 1) begin
            if (y >= 1)
                edges.push_back(is_edge_at(x - 1, y - 1, w, h, above_recent[1], a, top_last,
                                           left_pix[0]));
            if (last_row)
                edges.push_back(is_edge_at(x - 1, y, w, h, left_pix[1], p, 8'd0, 8'd0));
        end
        if (row_end) begin
            if (y >= 1)
                edges.push_back(is_edge_at(x, y - 1, w, h, above_recent[0], 8'd0, b, p));
            if (last_row)
                edges.push_back(is_edge_at(x, y, w, h, left_pix[0], 8'd0, 8'd0, 8'd0));
        end
        foreach (edges[i]) begin
            m.is_edge = edges[i];
            m.last_of_run = (i == edges.size() - 1);
            m.end_of_frame = m.last_of_run && row_end && last_row;
            marks_due.push_back(m);
        end
        above_recent[1] = above_recent[0];
        above_recent[0] = a;
        left_pix[1] = left_pix[0];
        left_pix[0] = p;
        top_last = b;
        line_two_above[x] = a;
        line_above[x] = p;
        if (row_end) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : y + 1;
        end else begin
            col_cnt = x + 1;
            row_cnt = y;
        end
    endfunction

    task report(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_mark(logic [7:0] data, logic last, logic eof);
        t_mark m;
        if (marks_due.size() == 0) begin
            report($sformatf("result with nothing expected, tdata=%h tlast=%b tuser=%b",
                             data, last, eof));
            return;
        end
        m = marks_due.pop_front();
        if (data[0] !== m.is_edge)
            report($sformatf("is_edge %b, expected %b", data[0], m.is_edge));
        if (data[7:1] !== 7'd0)
            report($sformatf("tdata padding %h is not zero", data[7:1]));
        if (last !== m.last_of_run)
            report($sformatf("last_of_run %b, expected %b", last, m.last_of_run));
        if (eof !== m.end_of_frame)
            report($sformatf("end_of_frame %b, expected %b", eof, m.end_of_frame));
    endtask
endclass

module gradient_edge_threshold_tb;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PIXELS = 370;
    localparam int CALM_AFTER = 300;
    localparam int DW = gedt_pkg::CFG_DATA_W;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    gedt_pkg::t_cfg_idx    i_cfg_index = gedt_pkg::CFG_IMAGE_WIDTH;
    logic [DW-1:0]         i_cfg_data = '0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;
    logic                  o_cfg_ready;

    edge_mark_scoreboard sb = new();
    bit                  calm = 1'b0;
    int unsigned         idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    gradient_edge_threshold u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_mark(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("[gradient_edge_threshold] ERROR");
        $finish;
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8)) @(posedge i_clk);
        end
    end

    task automatic put_register(gedt_pkg::t_cfg_idx idx, logic [DW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        sb.write_reg(idx, value);
    endtask

    task automatic set_registers(bit [2:0] which, logic [DW-1:0] w,
                                 logic [DW-1:0] h, logic [DW-1:0] thr);
        if (which[0]) put_register(gedt_pkg::CFG_IMAGE_WIDTH, w);
        if (which[1]) put_register(gedt_pkg::CFG_IMAGE_HEIGHT, h);
        if (which[2]) put_register(gedt_pkg::CFG_THRESHOLD_SQ, thr);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_pixel(p);
    endtask

    task automatic idle_stream(int unsigned n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Pixels that cause no result may still be in flight, hence the extra cycles.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The first pixel sits in the highest used byte.
    task automatic send_series(int n, logic [8*12-1:0] px);
        for (int i = n - 1; i >= 0; i--) send_pixel(px[8*i +: 8]);
    endtask

    task automatic run_frame(int unsigned style, int pause_at, bit steady, output int sent);
        logic [7:0] base = 8'($urandom_range(0, 255));
        logic [7:0] p;
        sent = 0;
        do begin
            if (sent == pause_at) begin
                settle();
                set_registers(3'($urandom_range(1, 7)), DW'($urandom_range(0, sb.eff_width())),
                              DW'($urandom_range(0, sb.eff_height() + 3)),
                              DW'($urandom_range(0, 3000)));
            end
            case (style)
                0: p = 8'($urandom_range(0, 255));
                1: begin
                    if ($urandom_range(0, 7) == 0) base = 8'($urandom_range(0, 255));
                    p = base + 8'($urandom_range(0, 12));
                end
                default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            send_pixel(p);
            sent++;
            if (!steady && !calm && $urandom_range(0, 5) == 0) idle_stream($urandom_range(1, 11));
        end while (!sb.at_frame_start());
    endtask

    initial begin
        int done_pixels;
        int frame_no;
        int sent;
        int r;
        int total;
        int pause_at;
        logic [DW-1:0] w;
        logic [DW-1:0] h;
        logic [DW-1:0] thr;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default frame size, then the width shrinks below the column already reached.
        set_registers(3'b100, '0, '0, 17'd0);
        send_series(3, {8'd255, 8'd0, 8'd255});
        settle();
        set_registers(3'b011, 17'd3, 17'd2, '0);
        send_series(4, {8'd0, 8'd255, 8'd0, 8'd255});
        settle();

        // Largest possible gradient on the center pixel just clears the threshold.
        set_registers(3'b111, 17'd3, 17'd3, 17'd130049);
        send_series(9, {8'd0, 8'd255, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd0, 8'd255});
        settle();

        // The height shrinks below the row already reached.
        set_registers(3'b111, 17'd4, 17'd6, 17'd131071);
        send_series(8, {8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255});
        settle();
        set_registers(3'b110, '0, 17'd2, 17'd100);
        send_series(4, {8'd0, 8'd0, 8'd255, 8'd255});
        settle();

        // Zero width and height act as a single pixel frame.
        set_registers(3'b111, 17'd0, 17'd0, 17'd0);
        send_series(2, {8'd255, 8'd0});
        settle();

        // The widest setting on a single row, then the width shrinks below the column reached.
        set_registers(3'b111, 17'd2047, 17'd1, 17'd500);
        send_series(5, {8'd0, 8'd255, 8'd0, 8'd40, 8'd255});
        settle();
        set_registers(3'b001, 17'd3, '0, '0);
        send_series(1, {8'd77});

        done_pixels = 0;
        frame_no = 0;
        while (done_pixels < RANDOM_PIXELS) begin
            calm = (done_pixels >= CALM_AFTER);
            if (frame_no <= 2 || $urandom_range(0, 2) != 0) begin
                settle();
                r = $urandom_range(0, 15);
                w = (r == 0) ? DW'(0) : (r == 1) ? DW'(1) :
                    (r == 2) ? DW'($urandom_range(9, 40)) : DW'($urandom_range(2, 8));
                r = $urandom_range(0, 9);
                h = (r == 0) ? DW'(0) : (r == 1) ? DW'(1) :
                    DW'($urandom_range(2, (w > 8) ? 3 : 7));
                r = $urandom_range(0, 7);
                thr = (r == 0) ? DW'(0) : (r == 1) ? DW'(130050) : (r == 2) ? DW'(131071) :
                      (r == 3) ? DW'($urandom_range(0, 131071)) : DW'($urandom_range(0, 4000));
                set_registers(3'b111, w, h, thr);
            end
            total = int'(sb.eff_width() * sb.eff_height());
            pause_at = -1;
            if (total > 1 && $urandom_range(0, 3) == 0)
                pause_at = int'($urandom_range(1, total - 1));
            run_frame($urandom_range(0, 2), pause_at, $urandom_range(0, 3) == 0, sent);
            done_pixels += sent;
            frame_no++;
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[gradient_edge_threshold] OK");
        end else begin
            $display("[gradient_edge_threshold] ERROR");
        end
        $finish;
    end
endmodule

FILE: gradient_edge_threshold.f
+incdir+hw/rtl
hw/rtl/gedt_pkg.sv
hw/rtl/gradient_edge_threshold.sv
verif/gradient_edge_threshold_tb.sv
